### src/mlpsgd_pkg.sv
package mlpsgd_pkg;

   localparam int N_IN = 2;
   localparam int N_HID = 3;
   localparam int N_OUT = 1;
   localparam int SIG_DEPTH = 256;

   localparam int VALUE_W = 16;
   localparam int INDEX_W = 4;
   localparam int CMD_W = 2;
   localparam int LR_W = 16;
   localparam logic [LR_W-1:0] LR_RESET = 16'd6554;

   localparam int HB_BASE = N_HID * N_IN;
   localparam int OW_BASE = HB_BASE + N_HID;
   localparam int OB_BASE = OW_BASE + N_OUT * N_HID;
   localparam int P_COUNT = OB_BASE + N_OUT;
   localparam int S_COUNT = N_IN + N_OUT;

   localparam int PA_W = (P_COUNT > 1) ? $clog2(P_COUNT) : 1;
   localparam int IN_IW = (N_IN > 1) ? $clog2(N_IN) : 1;
   localparam int HID_IW = (N_HID > 1) ? $clog2(N_HID) : 1;
   localparam int OUT_IW = (N_OUT > 1) ? $clog2(N_OUT) : 1;
   localparam int SMP_IW = (S_COUNT > 1) ? $clog2(S_COUNT) : 1;
   localparam int SIG_IW = $clog2(SIG_DEPTH);
   localparam int CNT_W = 5;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int ACC_W = MUL_A_W + MUL_B_W;
   localparam int Q_W = MUL_A_W;

   localparam int ONE_Q12 = 4096;
   localparam longint EXP_M1_Q30 = 64'd395007543;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_INFER = 2'd2,
      CMD_TRAIN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD
   } mac_op_type;

   typedef struct packed {
      mac_op_type               op;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mac_ctrl_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FH_BIAS,
      S_FH_MAC,
      S_FH_ACT,
      S_FO_BIAS,
      S_FO_MAC,
      S_FO_ACT,
      S_OD_DER,
      S_OD_MUL,
      S_OD_SAT,
      S_HE_MAC,
      S_HD_DER,
      S_HD_MUL,
      S_HD_SAT,
      S_OQ,
      S_OQ_CAP,
      S_OW_MUL,
      S_OW_WR,
      S_OB_WR,
      S_HQ,
      S_HQ_CAP,
      S_HW_MUL,
      S_HW_WR,
      S_HB_WR
   } seq_state_type;

   typedef logic signed [VALUE_W-1:0] sig_table_type [SIG_DEPTH];

   // Shift-and-subtract quotient of two non-negative numbers, used only while
   // the sigmoid table is built at elaboration.
   function automatic longint udiv(longint num, longint den);
      longint q, r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((num >>> b) & 1);
         if (r >= den) begin
            r = r - den;
            q = q | (longint'(1) <<< b);
         end
      end
      return q;
   endfunction

   // Sigmoid entries at the left edge of each bin, exp(-u) evaluated in Q30.
   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      longint t, u, n, e, den, s, sum, term, f;
      for (int k = 0; k < SIG_DEPTH; k++) begin
         t = -32768 + ((longint'(k) <<< 16) >>> SIG_IW);
         u = (t < 0) ? -t : t;
         n = u >>> 12;
         f = (u & 4095) <<< 18;
         sum = 64'd1 <<< 30;
         term = 64'd1 <<< 30;
         for (int m = 1; m <= 14; m++) begin
            term = udiv((term * f) >>> 30, longint'(m));
            if ((m & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         e = sum;
         for (int j = 0; j < 8; j++) begin
            if (j < n) begin
               e = (e * EXP_M1_Q30 + (64'd1 <<< 29)) >>> 30;
            end
         end
         den = (64'd1 <<< 30) + e;
         s = udiv((64'd1 <<< 42) + (den >>> 1), den);
         if (t < 0) begin
            s = ONE_Q12 - s;
         end
         tab[k] = VALUE_W'(s);
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   function automatic logic signed [ACC_W-1:0] rnd_shr(logic signed [ACC_W-1:0] v, int s);
      logic signed [ACC_W-1:0] half;
      half = ACC_W'(1) << (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat16(logic signed [ACC_W-1:0] v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[VALUE_W-1:0];
   endfunction

endpackage

### src/mlpsgd_mac.sv
module mlpsgd_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mlpsgd_pkg::mac_ctrl_type               ctrl,
   output logic signed [mlpsgd_pkg::ACC_W-1:0]    acc
);
   import mlpsgd_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] prod;

   assign prod = ctrl.a * ctrl.b;

   always_comb begin
      case (ctrl.op)
         MAC_LOAD: acc_in = prod;
         MAC_ADD:  acc_in = acc_ff + prod;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

### src/mlpsgd_sig.sv
module mlpsgd_sig (
   input  logic signed [mlpsgd_pkg::ACC_W-1:0]   acc,
   output logic signed [mlpsgd_pkg::VALUE_W-1:0] act
);
   import mlpsgd_pkg::*;

   logic signed [VALUE_W-1:0] x;
   logic [VALUE_W-1:0]        biased;
   logic [SIG_IW-1:0]         idx;

   // Offset binary of the saturated sum; its top bits pick the bin.
   assign x = sat16(rnd_shr(acc, 12));
   assign biased = x ^ 16'h8000;
   assign idx = biased[VALUE_W-1 -: SIG_IW];
   assign act = SIG_TABLE[idx];

endmodule

### src/mlp_sgd_train_infer_core.sv
// Parameter write and read act on acceptance; a read result is registered on the output.
// A last sample element runs the forward pass, one product per cycle through the shared
// multiply-accumulate unit; each output result waits until the output slot is free.
// Training then runs the backward pass and the weight and bias updates.
// No new transaction is taken until the sequence ends and the output slot is free.
// Synchronous reset clears control, learn_rate to 6554 and the activations to zero.
module mlp_sgd_train_infer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mlpsgd_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mlpsgd_pkg::INDEX_W-1:0]         req_index,
   input  logic signed [mlpsgd_pkg::VALUE_W-1:0]  req_value,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mlpsgd_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic [mlpsgd_pkg::INDEX_W-1:0]         rsp_result_index,
   output logic                                   rsp_result_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mlpsgd_pkg::LR_W-1:0]            csr_learn_rate
);
   import mlpsgd_pkg::*;

   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic train_ff, train_in;
   logic [LR_W-1:0] lr_ff;

   logic signed [VALUE_W-1:0] param_ff [P_COUNT];
   logic signed [VALUE_W-1:0] sample_ff [S_COUNT];
   logic signed [VALUE_W-1:0] hact_ff [N_HID];
   logic signed [VALUE_W-1:0] oact_ff [N_OUT];
   logic signed [VALUE_W-1:0] dout_ff [N_OUT];
   logic signed [VALUE_W-1:0] dhid_ff [N_HID];
   logic signed [VALUE_W-1:0] err_ff;
   logic signed [Q_W-1:0]     q_ff;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_load;

   mac_ctrl_type              mac_ctrl;
   logic signed [ACC_W-1:0]   acc;
   logic signed [VALUE_W-1:0] sig_act;
   logic signed [ACC_W-1:0]   acc_r12;
   logic signed [MUL_B_W-1:0] der;

   logic [PA_W-1:0]           p_addr;
   logic signed [VALUE_W-1:0] p_rdata;
   logic signed [ACC_W-1:0]   p_ext;
   logic                      p_we;
   logic signed [VALUE_W-1:0] p_wdata;
   logic                      sample_we, hact_we, oact_we, dout_we, dhid_we, err_we, q_we;

   logic req_fire, slot_free, ca_end_hid, ca_end_out, cb_end_in, cb_end_hid, cb_end_out;
   logic [HID_IW-1:0] ca_h, cb_h;
   logic [OUT_IW-1:0] ca_o, cb_o;
   logic [IN_IW-1:0]  cb_i;
   logic [SMP_IW-1:0] tgt_idx;

   mlpsgd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   mlpsgd_sig u_sig (
      .acc (acc),
      .act (sig_act)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign ca_h = ca_ff[HID_IW-1:0];
   assign cb_h = cb_ff[HID_IW-1:0];
   assign ca_o = ca_ff[OUT_IW-1:0];
   assign cb_o = cb_ff[OUT_IW-1:0];
   assign cb_i = cb_ff[IN_IW-1:0];
   assign tgt_idx = SMP_IW'(N_IN + int'(ca_ff));

   assign ca_end_hid = (ca_ff == CNT_W'(N_HID - 1));
   assign ca_end_out = (ca_ff == CNT_W'(N_OUT - 1));
   assign cb_end_in  = (cb_ff == CNT_W'(N_IN - 1));
   assign cb_end_hid = (cb_ff == CNT_W'(N_HID - 1));
   assign cb_end_out = (cb_ff == CNT_W'(N_OUT - 1));

   assign p_rdata = param_ff[p_addr];
   assign p_ext = ACC_W'(p_rdata);
   assign acc_r12 = rnd_shr(acc, 12);
   assign der = acc_r12[MUL_B_W-1:0];

   always_comb begin
      state_in = state_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      train_in = train_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_last && (req_cmd[1] == 1'b1)) begin
               state_in = S_FH_BIAS;
               ca_in = '0;
               cb_in = '0;
               train_in = (cmd_type'(req_cmd) == CMD_TRAIN);
            end
         end
         S_FH_BIAS: begin
            state_in = S_FH_MAC;
            cb_in = '0;
         end
         S_FH_MAC: begin
            if (cb_end_in) begin
               state_in = S_FH_ACT;
            end else begin
               cb_in = cb_ff + 1'b1;
            end
         end
         S_FH_ACT: begin
            ca_in = ca_end_hid ? '0 : ca_ff + 1'b1;
            state_in = ca_end_hid ? S_FO_BIAS : S_FH_BIAS;
         end
         S_FO_BIAS: begin
            state_in = S_FO_MAC;
            cb_in = '0;
         end
         S_FO_MAC: begin
            if (cb_end_hid) begin
               state_in = S_FO_ACT;
            end else begin
               cb_in = cb_ff + 1'b1;
            end
         end
         S_FO_ACT: begin
            if (slot_free) begin
               if (!ca_end_out) begin
                  ca_in = ca_ff + 1'b1;
                  state_in = S_FO_BIAS;
               end else begin
                  ca_in = '0;
                  state_in = train_ff ? S_OD_DER : S_IDLE;
               end
            end
         end
         S_OD_DER: state_in = S_OD_MUL;
         S_OD_MUL: state_in = S_OD_SAT;
         S_OD_SAT: begin
            cb_in = '0;
            ca_in = ca_end_out ? '0 : ca_ff + 1'b1;
            state_in = ca_end_out ? S_HE_MAC : S_OD_DER;
         end
         S_HE_MAC: begin
            if (cb_end_out) begin
               state_in = S_HD_DER;
            end else begin
               cb_in = cb_ff + 1'b1;
            end
         end
         S_HD_DER: state_in = S_HD_MUL;
         S_HD_MUL: state_in = S_HD_SAT;
         S_HD_SAT: begin
            cb_in = '0;
            ca_in = ca_end_hid ? '0 : ca_ff + 1'b1;
            state_in = ca_end_hid ? S_OQ : S_HE_MAC;
         end
         S_OQ: state_in = S_OQ_CAP;
         S_OQ_CAP: begin
            state_in = S_OW_MUL;
            cb_in = '0;
         end
         S_OW_MUL: state_in = S_OW_WR;
         S_OW_WR: begin
            if (cb_end_hid) begin
               state_in = S_OB_WR;
            end else begin
               cb_in = cb_ff + 1'b1;
               state_in = S_OW_MUL;
            end
         end
         S_OB_WR: begin
            ca_in = ca_end_out ? '0 : ca_ff + 1'b1;
            state_in = ca_end_out ? S_HQ : S_OQ;
         end
         S_HQ: state_in = S_HQ_CAP;
         S_HQ_CAP: begin
            state_in = S_HW_MUL;
            cb_in = '0;
         end
         S_HW_MUL: state_in = S_HW_WR;
         S_HW_WR: begin
            if (cb_end_in) begin
               state_in = S_HB_WR;
            end else begin
               cb_in = cb_ff + 1'b1;
               state_in = S_HW_MUL;
            end
         end
         S_HB_WR: begin
            ca_in = ca_end_hid ? '0 : ca_ff + 1'b1;
            state_in = ca_end_hid ? S_IDLE : S_HQ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mac_ctrl.op = MAC_HOLD;
      mac_ctrl.a = '0;
      mac_ctrl.b = '0;
      p_addr = PA_W'(req_index);
      p_we = 1'b0;
      p_wdata = req_value;
      sample_we = 1'b0;
      hact_we = 1'b0;
      oact_we = 1'b0;
      dout_we = 1'b0;
      dhid_we = 1'b0;
      err_we = 1'b0;
      q_we = 1'b0;
      rsp_load = 1'b0;
      rsp_value_in = p_rdata;
      rsp_index_in = req_index;
      rsp_last_in = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (cmd_type'(req_cmd))
                  CMD_WRITE: p_we = (int'(req_index) < P_COUNT);
                  CMD_READ: begin
                     rsp_load = 1'b1;
                     if (int'(req_index) >= P_COUNT) begin
                        rsp_value_in = '0;
                     end
                  end
                  default: sample_we = (int'(req_index) < S_COUNT);
               endcase
            end
         end
         S_FH_BIAS: begin
            p_addr = PA_W'(HB_BASE + int'(ca_ff));
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(p_rdata);
            mac_ctrl.b = MUL_B_W'(ONE_Q12);
         end
         S_FH_MAC: begin
            p_addr = PA_W'(int'(ca_ff) * N_IN + int'(cb_ff));
            mac_ctrl.op = MAC_ADD;
            mac_ctrl.a = MUL_A_W'(p_rdata);
            mac_ctrl.b = MUL_B_W'(sample_ff[cb_i]);
         end
         S_FH_ACT: hact_we = 1'b1;
         S_FO_BIAS: begin
            p_addr = PA_W'(OB_BASE + int'(ca_ff));
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(p_rdata);
            mac_ctrl.b = MUL_B_W'(ONE_Q12);
         end
         S_FO_MAC: begin
            p_addr = PA_W'(OW_BASE + int'(ca_ff) * N_HID + int'(cb_ff));
            mac_ctrl.op = MAC_ADD;
            mac_ctrl.a = MUL_A_W'(p_rdata);
            mac_ctrl.b = MUL_B_W'(hact_ff[cb_h]);
         end
         S_FO_ACT: begin
            if (slot_free) begin
               oact_we = 1'b1;
               rsp_load = 1'b1;
               rsp_value_in = sig_act;
               rsp_index_in = INDEX_W'(ca_ff);
               rsp_last_in = ca_end_out;
            end
         end
         S_OD_DER: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(oact_ff[ca_o]);
            mac_ctrl.b = MUL_B_W'(ONE_Q12) - MUL_B_W'(oact_ff[ca_o]);
         end
         S_OD_MUL: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(sample_ff[tgt_idx]) - MUL_A_W'(oact_ff[ca_o]);
            mac_ctrl.b = der;
         end
         S_OD_SAT: dout_we = 1'b1;
         S_HE_MAC: begin
            p_addr = PA_W'(OW_BASE + int'(cb_ff) * N_HID + int'(ca_ff));
            mac_ctrl.op = (cb_ff == '0) ? MAC_LOAD : MAC_ADD;
            mac_ctrl.a = MUL_A_W'(p_rdata);
            mac_ctrl.b = MUL_B_W'(dout_ff[cb_o]);
         end
         S_HD_DER: begin
            err_we = 1'b1;
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(hact_ff[ca_h]);
            mac_ctrl.b = MUL_B_W'(ONE_Q12) - MUL_B_W'(hact_ff[ca_h]);
         end
         S_HD_MUL: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(err_ff);
            mac_ctrl.b = der;
         end
         S_HD_SAT: dhid_we = 1'b1;
         S_OQ: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(dout_ff[ca_o]);
            mac_ctrl.b = $signed({2'b00, lr_ff});
         end
         S_OQ_CAP, S_HQ_CAP: q_we = 1'b1;
         S_OW_MUL: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = q_ff;
            mac_ctrl.b = MUL_B_W'(hact_ff[cb_h]);
         end
         S_OW_WR: begin
            p_addr = PA_W'(OW_BASE + int'(ca_ff) * N_HID + int'(cb_ff));
            p_we = 1'b1;
            p_wdata = sat16(p_ext + rnd_shr(acc, 28));
         end
         S_OB_WR: begin
            p_addr = PA_W'(OB_BASE + int'(ca_ff));
            p_we = 1'b1;
            p_wdata = sat16(p_ext + rnd_shr(ACC_W'(q_ff), 16));
         end
         S_HQ: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = MUL_A_W'(dhid_ff[ca_h]);
            mac_ctrl.b = $signed({2'b00, lr_ff});
         end
         S_HW_MUL: begin
            mac_ctrl.op = MAC_LOAD;
            mac_ctrl.a = q_ff;
            mac_ctrl.b = MUL_B_W'(sample_ff[cb_i]);
         end
         S_HW_WR: begin
            p_addr = PA_W'(int'(ca_ff) * N_IN + int'(cb_ff));
            p_we = 1'b1;
            p_wdata = sat16(p_ext + rnd_shr(acc, 28));
         end
         S_HB_WR: begin
            p_addr = PA_W'(HB_BASE + int'(ca_ff));
            p_we = 1'b1;
            p_wdata = sat16(p_ext + rnd_shr(ACC_W'(q_ff), 16));
         end
         default: begin
            mac_ctrl.op = MAC_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ca_ff <= '0;
         cb_ff <= '0;
         train_ff <= 1'b0;
         lr_ff <= LR_RESET;
         rsp_valid_ff <= 1'b0;
         for (int h = 0; h < N_HID; h++) begin
            hact_ff[h] <= '0;
         end
         for (int o = 0; o < N_OUT; o++) begin
            oact_ff[o] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ca_ff <= ca_in;
         cb_ff <= cb_in;
         train_ff <= train_in;
         if (csr_valid && csr_ready) begin
            lr_ff <= csr_learn_rate;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (hact_we) begin
            hact_ff[ca_h] <= sig_act;
         end
         if (oact_we) begin
            oact_ff[ca_o] <= sig_act;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         param_ff[p_addr] <= p_wdata;
      end
      if (sample_we) begin
         sample_ff[SMP_IW'(req_index)] <= req_value;
      end
      if (dout_we) begin
         dout_ff[ca_o] <= sat16(acc_r12);
      end
      if (dhid_we) begin
         dhid_ff[ca_h] <= sat16(acc_r12);
      end
      if (err_we) begin
         err_ff <= sat16(acc_r12);
      end
      if (q_we) begin
         q_ff <= acc[Q_W-1:0];
      end
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_last = rsp_last_ff;

endmodule

### test/tb_top.sv
module tb_top;
   import mlpsgd_pkg::*;

   typedef struct {
      cmd_type                   cmd;
      logic [INDEX_W-1:0]        idx;
      logic signed [VALUE_W-1:0] val;
      logic                      last;
      bit                        typed;
      logic signed [VALUE_W-1:0] typed_val;
   } stim_row_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      logic                      last;
   } net_result_type;

   localparam int NUM_DIRECTED = 24;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready, req_last;
   logic [CMD_W-1:0] req_cmd;
   logic [INDEX_W-1:0] req_index;
   logic signed [VALUE_W-1:0] req_value;
   logic rsp_valid, rsp_ready, rsp_result_last;
   logic signed [VALUE_W-1:0] rsp_result_value;
   logic [INDEX_W-1:0] rsp_result_index;
   logic csr_valid, csr_ready;
   logic [LR_W-1:0] csr_learn_rate;

   mlp_sgd_train_infer_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_index(req_index), .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_result_index(rsp_result_index),
      .rsp_result_last(rsp_result_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_learn_rate(csr_learn_rate)
   );

   always #4 clock = ~clock;

   // Network model state.
   logic signed [VALUE_W-1:0] sigmoid_rom [SIG_DEPTH];
   logic signed [VALUE_W-1:0] weights [P_COUNT];
   logic signed [VALUE_W-1:0] sample_regs [S_COUNT];
   logic signed [VALUE_W-1:0] hid_act [N_HID];
   logic signed [VALUE_W-1:0] out_act [N_OUT];
   logic [LR_W-1:0] rate;

   net_result_type expected_outputs[$];
   stim_row_type directed_rows [NUM_DIRECTED];
   int accepted_items = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int rx_cycle = 0;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [VALUE_W-1:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[VALUE_W-1:0];
   endfunction

   function automatic logic signed [VALUE_W-1:0] sigmoid(logic signed [VALUE_W-1:0] x);
      return sigmoid_rom[(longint'(x) + 32768) * SIG_DEPTH / 65536];
   endfunction

   function automatic longint slope(logic signed [VALUE_W-1:0] a);
      return round_shift(longint'(a) * (ONE_Q12 - longint'(a)), 12);
   endfunction

   task automatic fill_sigmoid_rom();
      longint t, u, e, den, s, total, term, frac;
      for (int k = 0; k < SIG_DEPTH; k++) begin
         t = -32768 + (longint'(k) * 65536) / SIG_DEPTH;
         u = (t < 0) ? -t : t;
         frac = (u & 4095) <<< 18;
         total = longint'(1) <<< 30;
         term = total;
         for (int m = 1; m <= 14; m++) begin
            term = ((term * frac) >>> 30) / m;
            total = (m % 2 == 1) ? total - term : total + term;
         end
         e = total;
         for (longint j = 0; j < (u >>> 12); j++) begin
            e = (e * EXP_M1_Q30 + (longint'(1) <<< 29)) >>> 30;
         end
         den = (longint'(1) <<< 30) + e;
         s = ((longint'(1) <<< 42) + den / 2) / den;
         if (t < 0) s = ONE_Q12 - s;
         sigmoid_rom[k] = s[VALUE_W-1:0];
      end
   endtask

   task automatic run_forward();
      longint acc;
      for (int h = 0; h < N_HID; h++) begin
         acc = longint'(weights[HB_BASE + h]) * ONE_Q12;
         for (int i = 0; i < N_IN; i++)
            acc += longint'(weights[h * N_IN + i]) * longint'(sample_regs[i]);
         hid_act[h] = sigmoid(clamp16(round_shift(acc, 12)));
      end
      for (int o = 0; o < N_OUT; o++) begin
         acc = longint'(weights[OB_BASE + o]) * ONE_Q12;
         for (int h = 0; h < N_HID; h++)
            acc += longint'(weights[OW_BASE + o * N_HID + h]) * longint'(hid_act[h]);
         out_act[o] = sigmoid(clamp16(round_shift(acc, 12)));
      end
   endtask

   task automatic run_backprop();
      logic signed [VALUE_W-1:0] d_out [N_OUT];
      logic signed [VALUE_W-1:0] d_hid [N_HID];
      logic signed [VALUE_W-1:0] err;
      longint acc, lr;
      int p;
      lr = longint'(rate);
      for (int o = 0; o < N_OUT; o++)
         d_out[o] = clamp16(round_shift((longint'(sample_regs[N_IN + o]) - out_act[o])
                                        * slope(out_act[o]), 12));
      // Hidden errors must see the output weights before they move.
      for (int h = 0; h < N_HID; h++) begin
         acc = 0;
         for (int o = 0; o < N_OUT; o++)
            acc += longint'(weights[OW_BASE + o * N_HID + h]) * longint'(d_out[o]);
         err = clamp16(round_shift(acc, 12));
         d_hid[h] = clamp16(round_shift(longint'(err) * slope(hid_act[h]), 12));
      end
      for (int o = 0; o < N_OUT; o++) begin
         for (int h = 0; h < N_HID; h++) begin
            p = OW_BASE + o * N_HID + h;
            weights[p] = clamp16(longint'(weights[p])
               + round_shift(lr * longint'(d_out[o]) * longint'(hid_act[h]), 28));
         end
         weights[OB_BASE + o] = clamp16(longint'(weights[OB_BASE + o])
            + round_shift(lr * longint'(d_out[o]), 16));
      end
      for (int h = 0; h < N_HID; h++) begin
         for (int i = 0; i < N_IN; i++) begin
            p = h * N_IN + i;
            weights[p] = clamp16(longint'(weights[p])
               + round_shift(lr * longint'(d_hid[h]) * longint'(sample_regs[i]), 28));
         end
         weights[HB_BASE + h] = clamp16(longint'(weights[HB_BASE + h])
            + round_shift(lr * longint'(d_hid[h]), 16));
      end
   endtask

   task automatic predict_item(cmd_type cmd, logic [INDEX_W-1:0] idx,
                               logic signed [VALUE_W-1:0] val, logic last);
      net_result_type r;
      case (cmd)
         CMD_WRITE: begin
            if (idx < P_COUNT) weights[idx] = val;
         end
         CMD_READ: begin
            r.value = (idx < P_COUNT) ? weights[idx] : '0;
            r.index = idx;
            r.last = 1'b1;
            expected_outputs.push_back(r);
         end
         default: begin
            if (idx < S_COUNT) sample_regs[idx] = val;
            if (last) begin
               run_forward();
               for (int o = 0; o < N_OUT; o++) begin
                  r.value = out_act[o];
                  r.index = INDEX_W'(o);
                  r.last = (o == N_OUT - 1);
                  expected_outputs.push_back(r);
               end
               if (cmd == CMD_TRAIN) run_backprop();
            end
         end
      endcase
   endtask

   // Input side: predict at acceptance, using the values present at the edge.
   always @(posedge clock) begin
      net_result_type r;
      if (!reset && req_valid && req_ready) begin
         if (accepted_items < NUM_DIRECTED && directed_rows[accepted_items].typed) begin
            predict_item(cmd_type'(req_cmd), req_index, req_value, req_last);
            r = expected_outputs.pop_back();
            r.value = directed_rows[accepted_items].typed_val;
            expected_outputs.push_back(r);
         end else begin
            predict_item(cmd_type'(req_cmd), req_index, req_value, req_last);
         end
         accepted_items++;
      end
   end

   // Result side: compare every transaction with the oldest expectation.
   always @(posedge clock) begin
      net_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d index %0d last %0b",
                        rsp_result_value, rsp_result_index, rsp_result_last);
         end else begin
            r = expected_outputs.pop_front();
            if (r.value !== rsp_result_value || r.index !== rsp_result_index
                || r.last !== rsp_result_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                           r.value, r.index, r.last,
                           rsp_result_value, rsp_result_index, rsp_result_last);
            end
         end
      end
   end

   // The receiver cycles through full speed, random, heavy and periodic stalls.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle >> 7) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (rx_cycle % 8 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   int burst_left = 0;

   task automatic send_item(cmd_type cmd, logic [INDEX_W-1:0] idx,
                            logic signed [VALUE_W-1:0] val, logic last);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_index <= idx;
      req_value <= val;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      // A training pass keeps running after its result has gone out.
      repeat (100) @(posedge clock);
   endtask

   task automatic write_rate(logic [LR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_learn_rate <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rate = v;
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return VALUE_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return VALUE_W'($signed($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   task automatic random_phase(int count);
      int sent;
      int order [S_COUNT];
      int j, tmp;
      cmd_type mode;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0: begin
               send_item(CMD_WRITE, INDEX_W'($urandom_range(0, 15)), random_value(),
                         1'($urandom_range(0, 1)));
               sent++;
            end
            1: begin
               send_item(CMD_READ, INDEX_W'($urandom_range(0, 15)), VALUE_W'($urandom),
                         1'($urandom_range(0, 1)));
               sent++;
            end
            2: begin
               // Noise: any sample command, index and last.
               send_item(cmd_type'($urandom_range(2, 3)), INDEX_W'($urandom_range(0, 15)),
                         VALUE_W'($urandom), 1'($urandom_range(0, 1)));
               sent++;
            end
            default: begin
               // A whole sample in shuffled order; the last element chooses the mode.
               for (int k = 0; k < S_COUNT; k++) order[k] = k;
               for (int k = S_COUNT - 1; k > 0; k--) begin
                  j = $urandom_range(0, k);
                  tmp = order[k]; order[k] = order[j]; order[j] = tmp;
               end
               mode = $urandom_range(0, 3) != 0 ? CMD_TRAIN : CMD_INFER;
               for (int k = 0; k < S_COUNT; k++) begin
                  send_item(k == S_COUNT - 1 ? mode : cmd_type'($urandom_range(2, 3)),
                            INDEX_W'(order[k]), random_value(), k == S_COUNT - 1);
                  sent++;
               end
            end
         endcase
      end
      drain();
   endtask

   initial begin
      fill_sigmoid_rom();
      foreach (hid_act[h]) hid_act[h] = '0;
      foreach (out_act[o]) out_act[o] = '0;
      rate = LR_RESET;
      directed_rows = '{
         '{CMD_WRITE, 4'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd1,  16'sh8000, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd2,  16'sh1000, 1'b1, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd3,  -16'sd2048, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd4,  16'sh0800, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd5,  16'sh1800, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd6,  16'sh0000, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd7,  -16'sd4096, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd8,  16'sh0400, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd9,  16'sh2000, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd10, -16'sd8192, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd11, 16'sh1000, 1'b0, 1'b0, 16'sh0},
         '{CMD_WRITE, 4'd12, 16'sh0200, 1'b0, 1'b0, 16'sh0},
         '{CMD_READ,  4'd0,  16'sh0000, 1'b0, 1'b1, 16'sh7fff},
         '{CMD_READ,  4'd1,  16'sh5555, 1'b1, 1'b1, 16'sh8000},
         '{CMD_WRITE, 4'd14, 16'sh1234, 1'b0, 1'b0, 16'sh0},
         '{CMD_READ,  4'd15, 16'sh0000, 1'b0, 1'b1, 16'sh0000},
         '{CMD_INFER, 4'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0},
         '{CMD_TRAIN, 4'd1,  16'sh7fff, 1'b0, 1'b0, 16'sh0},
         '{CMD_INFER, 4'd2,  16'sh1000, 1'b1, 1'b0, 16'sh0},
         '{CMD_TRAIN, 4'd2,  16'sh0000, 1'b1, 1'b0, 16'sh0},
         '{CMD_TRAIN, 4'd9,  16'sh7fff, 1'b1, 1'b0, 16'sh0},
         '{CMD_READ,  4'd12, 16'sh0000, 1'b0, 1'b0, 16'sh0},
         '{CMD_INFER, 4'd0,  16'sh0800, 1'b1, 1'b0, 16'sh0}
      };
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_WRITE;
      req_index <= '0;
      req_value <= '0;
      req_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_learn_rate <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < NUM_DIRECTED; n++)
         send_item(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].val,
                   directed_rows[n].last);
      drain();
      random_phase(40);
      write_rate(16'hffff);
      random_phase(40);
      write_rate(16'h0000);
      random_phase(30);
      write_rate(16'h0001);
      random_phase(30);
      write_rate(LR_W'($urandom));
      random_phase(40);

      if (mismatches == 0 && expected_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
